>>> rtl/spq_pkg.sv
// Package for the sorted priority queue: sizes, status codes and request/response types.
// No dependencies; every rtl file references it by scoped names.
`default_nettype none
package spq_pkg;
    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CNT_XW  = (CNT_W > 5) ? CNT_W : 5;
    localparam int FILL_W  = 5;
    localparam int ID_W    = 16;
    localparam int PRIO_W  = 8;
    localparam int STAT_W  = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef struct packed {
        logic              func;
        logic [ID_W-1:0]   item_id;
        logic [PRIO_W-1:0] prio;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   out_id;
        logic [FILL_W-1:0] fill;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic del;
    } t_ctl;
endpackage
`default_nettype wire

>>> rtl/sorted_priority_queue_core.sv
// Sorted priority queue: a row of DEPTH compare-and-shift cells with a fill count.
// Response valid is registered and rises in the cycle after request accept; one request per cycle when not stalled.
// Throughput is set by the output register: a request is taken whenever the
// response register is empty or being drained in the same cycle.
// Reset (synchronous, active low) clears the fill count and response valid;
// cell contents are left as they are and read only below the fill count.
`default_nettype none
module sorted_priority_queue_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire spq_pkg::t_req  i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_ready,
    output spq_pkg::t_rsp      o_rsp
);
    localparam int D = spq_pkg::DEPTH;

    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] n_count;
    logic                      r_rsp_valid;
    spq_pkg::t_rsp             r_rsp;
    spq_pkg::t_rsp             n_rsp;

    logic            req_fire;
    logic            is_full;
    logic            is_empty;
    spq_pkg::t_ctl   ctl;
    spq_pkg::t_entry new_entry;
    spq_pkg::t_entry cell_q  [D];
    logic            cell_go [D];
    logic            cell_vld[D];
    logic [spq_pkg::CNT_XW-1:0] fill_x;

    // Take a request when the response slot is free or draining now.
    assign o_req_ready = !r_rsp_valid || i_rsp_ready;
    assign req_fire    = i_req_valid && o_req_ready;
    assign is_full     = (r_count == spq_pkg::CNT_W'(D));
    assign is_empty    = (r_count == '0);

    assign new_entry.id   = i_req.item_id;
    assign new_entry.prio = i_req.prio;

    // Broadcast the shift command; dropped requests leave the chain untouched.
    assign ctl.ins = req_fire && (i_req.func == spq_pkg::FUNC_ENQ) && !is_full;
    assign ctl.del = req_fire && (i_req.func == spq_pkg::FUNC_DEQ) && !is_empty;

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            spq_pkg::t_entry left_e;
            spq_pkg::t_entry right_e;
            logic            left_go;

            assign cell_vld[g] = (spq_pkg::CNT_W'(g) < r_count);

            if (g == 0) begin : g_head
                assign left_e  = new_entry;
                assign left_go = 1'b0;
            end else begin : g_mid
                assign left_e  = cell_q[g-1];
                assign left_go = cell_go[g-1];
            end

            if (g == D - 1) begin : g_tail
                assign right_e = new_entry;
            end else begin : g_body
                assign right_e = cell_q[g+1];
            end

            spq_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (ctl),
                .i_valid   (cell_vld[g]),
                .i_new     (new_entry),
                .i_left    (left_e),
                .i_left_go (left_go),
                .i_right   (right_e),
                .o_entry   (cell_q[g]),
                .o_go      (cell_go[g])
            );
        end
    endgenerate

    // Next count and response for the request at hand.
    always_comb begin
        n_count       = r_count;
        n_rsp         = r_rsp;
        n_rsp.status  = spq_pkg::ST_OK;
        n_rsp.out_id  = '0;
        if (i_req.func == spq_pkg::FUNC_ENQ) begin
            if (is_full) begin
                n_rsp.status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (is_empty) begin
                n_rsp.status = spq_pkg::ST_EMPTY;
            end else begin
                n_count      = r_count - 1'b1;
                n_rsp.out_id = cell_q[0].id;
            end
        end
        fill_x     = '0;
        fill_x[spq_pkg::CNT_W-1:0] = n_count;
        n_rsp.fill = fill_x[spq_pkg::FILL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (req_fire) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
        // Hold the response payload until a new request replaces it.
        if (req_fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::CNT_W'(D))
        else $error("fill count above depth");

    // An accepted insert with room grows the count by one.
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ins |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow count");

    // An empty-status response reports no id while the fill count is zero.
    a_empty_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_rsp.status == spq_pkg::ST_EMPTY) |->
            (r_rsp.out_id == '0 && r_count == '0))
        else $error("empty response inconsistent");

    // Insert and delete are never commanded together.
    a_ctl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.ins && ctl.del))
        else $error("insert and delete at once");
endmodule
`default_nettype wire

>>> rtl/spq_cell.sv
// One storage cell of the sorted chain: holds one entry, shifts with its neighbors.
// Depends on spq_pkg.
`default_nettype none
module spq_cell (
    input  wire logic           i_clk,
    input  wire spq_pkg::t_ctl   i_ctl,
    input  wire logic           i_valid,
    input  wire spq_pkg::t_entry i_new,
    input  wire spq_pkg::t_entry i_left,
    input  wire logic           i_left_go,
    input  wire spq_pkg::t_entry i_right,
    output spq_pkg::t_entry     o_entry,
    output logic                o_go
);
    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // Cell gives way when empty or holding a strictly larger priority value.
    assign o_go    = !i_valid || (r_entry.prio > i_new.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.del) begin
            n_entry = i_right;
        end else if (i_ctl.ins && o_go) begin
            n_entry = i_left_go ? i_left : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end
endmodule
`default_nettype wire
